// File: src/tsc_pkg.sv
package tsc_pkg;

    localparam int unsigned FIELD_W = 16;

    typedef logic [FIELD_W-1:0] coord_t;
    typedef logic [2:0]         gesture_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    // Event decode codes
    localparam logic [15:0] EVT_KEY   = 16'd1;
    localparam logic [15:0] EVT_ABS   = 16'd3;
    localparam logic [15:0] AXIS_X    = 16'd0;
    localparam logic [15:0] AXIS_Y    = 16'd1;
    localparam logic [15:0] KEY_TOUCH = 16'd330;
    localparam logic [15:0] KEY_PRESS   = 16'd1;
    localparam logic [15:0] KEY_RELEASE = 16'd0;

    // Gesture codes
    localparam gesture_t G_RIGHT = 3'd0;
    localparam gesture_t G_LEFT  = 3'd1;
    localparam gesture_t G_DOWN  = 3'd2;
    localparam gesture_t G_UP    = 3'd3;
    localparam gesture_t G_CLICK = 3'd4;

    localparam logic [15:0] THRESHOLD_RESET = 16'd100;

    // floor(n/5) == (n * RECIP_5) >> RECIP_SHIFT for every n below 2^18
    localparam int unsigned RECIP_SHIFT = 22;
    localparam logic [19:0] RECIP_5     = 20'd838861;

endpackage

// File: src/touch_swipe_classifier_unit.sv
// Flow: a request reaches the input register on acceptance; a release result is then
//   loaded into the result register, which drives m_axis_tvalid, once that slot is free.
// Throughput: one request per cycle; only a release request holds in the input register
//   while the result register is full and m_axis_tready is low.
// Reset: rst_n asynchronous active low; clears touch state, coordinates, valids,
//   and sets the swipe threshold to 100.
module touch_swipe_classifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: swipe_threshold
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input events
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] event_code, [31:16] event_value
    input  logic [15:0] s_axis_tuser,   // [15:0] event_type
    // gesture results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [2:0] gesture, [18:3] end_x, [34:19] end_y, rest 0
);
    import tsc_pkg::*;

    // Input register: holds one accepted request until it is processed.
    logic        in_valid_reg, in_valid_next;
    logic [15:0] in_type_reg, in_code_reg, in_value_reg;

    // Tracking state
    logic        touching_reg, touching_next;
    point_t      cur_reg, cur_next;
    point_t      start_reg, start_next;
    coord_t      threshold_reg;

    // Result register
    logic        out_valid_reg, out_valid_next;
    gesture_t    gesture_reg;
    point_t      end_reg;

    // Decode and control
    logic        is_abs, is_x, is_y, is_touch_key;
    logic        press, release_evt;
    logic        out_free;
    logic        proceed;
    coord_t      x_scaled, y_scaled;
    gesture_t    gesture_c;

    tsc_scaler u_scaler (
        .raw      (in_value_reg),
        .x_scaled (x_scaled),
        .y_scaled (y_scaled)
    );

    // Release uses the current point as the end point.
    tsc_classify u_classify (
        .start_pt  (start_reg),
        .end_pt    (cur_reg),
        .threshold (threshold_reg),
        .gesture   (gesture_c)
    );

    assign is_abs       = (in_type_reg == EVT_ABS);
    assign is_x         = is_abs && (in_code_reg == AXIS_X);
    assign is_y         = is_abs && (in_code_reg == AXIS_Y);
    assign is_touch_key = (in_type_reg == EVT_KEY) && (in_code_reg == KEY_TOUCH);
    assign press        = is_touch_key && (in_value_reg == KEY_PRESS) && !touching_reg;
    assign release_evt  = is_touch_key && (in_value_reg == KEY_RELEASE) && touching_reg;

    // Hold the request only when it would emit a result into an occupied slot.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proceed       = in_valid_reg && (out_free || !release_evt);
    assign s_axis_tready = !in_valid_reg || proceed;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_comb
    begin
        touching_next = touching_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        if (proceed)
        begin
            if (is_x)
            begin
                cur_next.x = x_scaled;
            end
            if (is_y)
            begin
                cur_next.y = y_scaled;
            end
            if (press)
            begin
                start_next    = cur_reg;
                touching_next = 1'b1;
            end
            if (release_evt)
            begin
                touching_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proceed && release_evt)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            touching_reg  <= 1'b0;
            cur_reg       <= '0;
            start_reg     <= '0;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            touching_reg  <= touching_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: capture on accept, load result on release.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_type_reg  <= s_axis_tuser;
            in_code_reg  <= s_axis_tdata[15:0];
            in_value_reg <= s_axis_tdata[31:16];
        end
        if (proceed && release_evt)
        begin
            gesture_reg <= gesture_c;
            end_reg     <= cur_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, end_reg.y, end_reg.x, gesture_reg};

    // A new result appears only after a release request went through.
    a_result_from_release: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proceed && release_evt))
        else $error("result appeared without a processed release");

    // After a release is processed the block is no longer touching.
    a_release_clears_touch: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && release_evt) |=> !touching_reg)
        else $error("touch state not cleared by release");

    // A stalled input side always means a request is held in the input register.
    a_stall_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked request");

    // Every presented gesture is a defined code.
    a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (gesture_reg <= G_CLICK))
        else $error("undefined gesture code presented");

endmodule

// File: src/tsc_scaler.sv
module tsc_scaler (
    input  tsc_pkg::coord_t raw,
    output tsc_pkg::coord_t x_scaled,
    output tsc_pkg::coord_t y_scaled
);
    import tsc_pkg::*;

    logic [20:0] x_times25;
    logic [17:0] y_times4;
    logic [37:0] y_prod;

    // x*800/1024 == x*25/32
    assign x_times25 = {raw, 4'b0000} + {1'b0, raw, 3'b000} + {5'b00000, raw};
    assign x_scaled  = x_times25[20:5];

    // y*480/600 == y*4/5, divide by 5 through a reciprocal multiply
    assign y_times4 = {raw, 2'b00};
    assign y_prod   = {20'd0, y_times4} * {18'd0, RECIP_5};
    assign y_scaled = y_prod[RECIP_SHIFT +: FIELD_W];

endmodule

// File: src/tsc_classify.sv
module tsc_classify (
    input  tsc_pkg::point_t   start_pt,
    input  tsc_pkg::point_t   end_pt,
    input  tsc_pkg::coord_t   threshold,
    output tsc_pkg::gesture_t gesture
);
    import tsc_pkg::*;

    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] thr_pos;
    logic signed [17:0] thr_neg;

    assign dx      = $signed({2'b00, end_pt.x}) - $signed({2'b00, start_pt.x});
    assign dy      = $signed({2'b00, end_pt.y}) - $signed({2'b00, start_pt.y});
    assign thr_pos = $signed({2'b00, threshold});
    assign thr_neg = -thr_pos;

    always_comb
    begin
        priority if (dx > thr_pos)
        begin
            gesture = G_RIGHT;
        end
        else if (dx < thr_neg)
        begin
            gesture = G_LEFT;
        end
        else if (dy > thr_pos)
        begin
            gesture = G_DOWN;
        end
        else if (dy < thr_neg)
        begin
            gesture = G_UP;
        end
        else
        begin
            gesture = G_CLICK;
        end
    end

endmodule

// File: tb/tb_touch_swipe_classifier_unit.sv
module tb_touch_swipe_classifier_unit;

    import tsc_pkg::*;

    // Cycles without any handshake on s_axis or m_axis before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned ITEMS_PER_PHASE = 130;
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned MAX_REPORTS = 10;

    // One touch event as it travels on s_axis.
    typedef struct packed {
        logic [15:0] etype;
        logic [15:0] code;
        logic [15:0] value;
    } touch_event_t;

    // One classified gesture as it travels on m_axis.
    typedef struct packed {
        gesture_t gesture;
        coord_t   end_x;
        coord_t   end_y;
    } gesture_rec_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] event_code, [31:16] event_value
    logic [15:0] s_axis_tuser = '0;   // [15:0] event_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [2:0] gesture, [18:3] end_x, [34:19] end_y

    touch_swipe_classifier_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow of the gesture detector: touch state, coordinates and threshold.
    logic        pen_down = 1'b0;
    coord_t      cur_x = '0;
    coord_t      cur_y = '0;
    coord_t      anchor_x = '0;
    coord_t      anchor_y = '0;
    logic [15:0] swipe_thr = THRESHOLD_RESET;

    touch_event_t event_q[$];     // requests waiting for the driver
    gesture_rec_t gesture_q[$];   // gestures predicted but not yet seen
    touch_event_t event_now;      // request currently offered on s_axis

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned miss_count = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Advance the shadow state by one event; return 1 when a gesture comes out.
    function automatic bit apply_event(input touch_event_t ev, output gesture_rec_t rec);
        int dx;
        int dy;
        int thr;
        rec = '0;
        if (ev.etype == EVT_ABS) begin
            if (ev.code == AXIS_X)
                cur_x = coord_t'((32'(ev.value) * 32'd800) / 32'd1024);
            else if (ev.code == AXIS_Y)
                cur_y = coord_t'((32'(ev.value) * 32'd480) / 32'd600);
            return 1'b0;
        end
        if (ev.etype != EVT_KEY || ev.code != KEY_TOUCH)
            return 1'b0;
        if (ev.value == KEY_PRESS && !pen_down) begin
            anchor_x = cur_x;
            anchor_y = cur_y;
            pen_down = 1'b1;
            return 1'b0;
        end
        if (ev.value == KEY_RELEASE && pen_down) begin
            pen_down = 1'b0;
            thr = int'(swipe_thr);
            dx = int'(cur_x) - int'(anchor_x);
            dy = int'(cur_y) - int'(anchor_y);
            // priority: right, left, down, up, then click
            if (dx > thr)
                rec.gesture = G_RIGHT;
            else if (dx < -thr)
                rec.gesture = G_LEFT;
            else if (dy > thr)
                rec.gesture = G_DOWN;
            else if (dy < -thr)
                rec.gesture = G_UP;
            else
                rec.gesture = G_CLICK;
            rec.end_x = cur_x;
            rec.end_y = cur_y;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_event(input logic [15:0] etype, input logic [15:0] code,
                              input logic [15:0] value);
        touch_event_t ev;
        ev.etype = etype;
        ev.code  = code;
        ev.value = value;
        event_q.push_back(ev);
    endtask

    function automatic logic [15:0] nudge(input logic [15:0] base, input int unsigned reach);
        int v;
        v = int'(base);
        if ($urandom_range(1))
            v = v + int'($urandom_range(reach));
        else
            v = v - int'($urandom_range(reach));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Touch: place the finger, press (sometimes twice), slide, lift (sometimes twice).
    task automatic add_swipe();
        logic [15:0] bx;
        logic [15:0] by;
        int unsigned reach;
        int unsigned moves;
        bx = 16'($urandom);
        by = 16'($urandom);
        if ($urandom_range(3) == 0)
            reach = 65535;
        else
            reach = (int'(swipe_thr) * 5) / 2 + 40;
        if (reach > 65535)
            reach = 65535;
        moves = $urandom_range(1, 3);
        push_event(EVT_ABS, AXIS_X, bx);
        push_event(EVT_ABS, AXIS_Y, by);
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
        if ($urandom_range(7) == 0)
            push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
        repeat (moves)
        begin
            if ($urandom_range(1))
                push_event(EVT_ABS, AXIS_X, nudge(bx, reach));
            else
                push_event(EVT_ABS, AXIS_Y, nudge(by, reach));
        end
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);
        if ($urandom_range(7) == 0)
            push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);
    endtask

    // Noise: stray events, odd key values, unknown types and codes.
    task automatic add_noise();
        case ($urandom_range(5))
            0: push_event(16'($urandom), 16'($urandom), 16'($urandom));
            1: push_event(EVT_KEY, KEY_TOUCH, 16'($urandom));
            2: push_event(EVT_ABS, 16'($urandom), 16'($urandom));
            3: push_event(EVT_KEY, 16'($urandom), $urandom_range(1) ? KEY_PRESS : KEY_RELEASE);
            4: push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
            default: push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);
        endcase
    endtask

    // Hold until every request is taken and every gesture has arrived, then
    // let the pipeline drain of requests that produce nothing.
    task automatic wait_idle();
        @(negedge clk);
        while (event_q.size() != 0 || s_axis_tvalid || gesture_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] thr);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        swipe_thr = thr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic report_miss(input string what, input gesture_rec_t want,
                               input gesture_rec_t got);
        miss_count++;
        if (miss_count <= MAX_REPORTS)
            $display("mismatch %s: expected gesture %0d x %0d y %0d, got gesture %0d x %0d y %0d",
                     what, want.gesture, want.end_x, want.end_y,
                     got.gesture, got.end_x, got.end_y);
    endtask

    // Driver: offer queued requests, predict each one as it is accepted.
    always @(posedge clk)
    begin
        gesture_rec_t rec;
        if (s_axis_tvalid && s_axis_tready) begin
            if (apply_event(event_now, rec))
                gesture_q.push_back(rec);
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (rst_n && event_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                event_now = event_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {event_now.value, event_now.code};
                s_axis_tuser  <= event_now.etype;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted gesture against the oldest prediction.
    always @(posedge clk)
    begin
        gesture_rec_t got;
        gesture_rec_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.gesture = m_axis_tdata[2:0];
            got.end_x   = m_axis_tdata[18:3];
            got.end_y   = m_axis_tdata[34:19];
            if (gesture_q.size() == 0) begin
                report_miss("unexpected result", '0, got);
            end else begin
                want = gesture_q.pop_front();
                if (got.gesture !== want.gesture)
                    report_miss("gesture", want, got);
                else if (got.end_x !== want.end_x)
                    report_miss("end_x", want, got);
                else if (got.end_y !== want.end_y)
                    report_miss("end_y", want, got);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: abandon the run when no request or result moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [15:0] thr_plan [PHASE_COUNT];
        int unsigned pushed;
        thr_plan[0] = 16'd0;
        thr_plan[1] = 16'hFFFF;
        thr_plan[2] = 16'($urandom);
        thr_plan[3] = 16'd1;
        thr_plan[4] = 16'd50000;
        thr_plan[5] = 16'($urandom_range(300));
        thr_plan[6] = THRESHOLD_RESET;
        thr_plan[7] = 16'($urandom_range(2000));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at the reset threshold of 100.
        @(negedge clk);
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);      // press before any axis event
        push_event(EVT_ABS, AXIS_X, 16'hFFFF);
        push_event(EVT_ABS, AXIS_Y, 16'hFFFF);
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);    // right, full travel
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);    // release while released
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);      // press while pressed
        push_event(EVT_ABS, AXIS_X, 16'h0000);
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);    // left
        push_event(EVT_ABS, AXIS_X, 16'd128);           // scales to exactly 100
        push_event(EVT_ABS, AXIS_Y, 16'h0000);
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
        push_event(EVT_ABS, AXIS_Y, 16'hFFFF);
        push_event(EVT_KEY, KEY_TOUCH, 16'd2);          // odd key value
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);    // down
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
        push_event(EVT_ABS, AXIS_Y, 16'h0000);
        push_event(16'hFFFF, KEY_TOUCH, KEY_RELEASE);   // unknown type
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);    // up
        push_event(EVT_KEY, KEY_TOUCH, KEY_PRESS);
        push_event(EVT_ABS, AXIS_X, 16'd256);           // travel equal to threshold
        push_event(EVT_ABS, 16'hFFFF, 16'hFFFF);        // unknown axis code
        push_event(EVT_KEY, 16'd331, KEY_RELEASE);      // other key
        push_event(EVT_KEY, KEY_TOUCH, KEY_RELEASE);    // click
        wait_idle();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_threshold(thr_plan[p]);
            @(negedge clk);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
                default: begin src_idle_pct = 20; snk_stall_pct = 20; end
            endcase
            pushed = 0;
            while (pushed < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 75)
                    add_swipe();
                else
                    add_noise();
                pushed = event_q.size();
            end
            wait_idle();
        end

        @(negedge clk);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (miss_count == 0 && gesture_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
